[hw/rtl/rtp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rtp_pkg;

    // NAL unit type codes of interest
    localparam logic [4:0] TYPE_FIRST_OTHER = 5'd24;  // first type that is not a single NAL unit
    localparam logic [4:0] TYPE_FU_A        = 5'd28;

    // Annex B start code: two zero bytes then this one
    localparam logic [7:0] START_ZERO = 8'h00;
    localparam logic [7:0] START_LAST = 8'h01;

    // result beats of the start code plus rebuilt header: 0, 1, 2 prefix, 3 header
    localparam logic [1:0] STEP_FIRST  = 2'd0;
    localparam logic [1:0] STEP_ZERO_B = 2'd1;
    localparam logic [1:0] STEP_ONE    = 2'd2;
    localparam logic [1:0] STEP_HEADER = 2'd3;

    // default depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // where we are inside a packet
    typedef enum logic [1:0] {
        POS_HDR   = 2'd0,   // expecting packet header
        POS_FUHDR = 2'd1,   // expecting FU header
        POS_BODY  = 2'd2    // packet body
    } t_pos;

    // what the current packet is
    typedef enum logic [1:0] {
        KIND_DROP   = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_FU_A   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       first_of_packet;
        logic       last_of_packet;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       unit_end;
        logic       unit_abort;
        logic       last_of_item;
    } t_out_item;

    // one queued command: either a start code plus a byte, or a single result
    typedef struct packed {
        logic       prefix;      // emit 00 00 01 before the byte
        logic [7:0] data;
        logic       has_byte;
        logic       unit_end;
        logic       unit_abort;  // on the first beat of the command
    } t_cmd;

endpackage

`default_nettype wire

[hw/rtl/rtp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtp_front
    import rtp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_item,
    input  wire logic     i_accept,
    output logic          o_cmd_valid,
    output t_cmd          o_cmd
);

    t_pos       r_pos,      n_pos;
    t_kind      r_kind,     n_kind;
    logic [2:0] r_f_nri,    n_f_nri;
    logic       r_in_frag,  n_in_frag;
    logic       r_frag_end, n_frag_end;

    logic [4:0] nal_type;
    logic       truncated;
    logic       ab;
    logic       fu_s;
    logic       fu_e;
    logic       last;

    // classify the byte and work out the packet state after it
    always_comb begin
        n_pos       = r_pos;
        n_kind      = r_kind;
        n_f_nri     = r_f_nri;
        n_in_frag   = r_in_frag;
        n_frag_end  = r_frag_end;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;

        nal_type  = i_item.payload_byte[4:0];
        truncated = (r_pos != POS_HDR);
        fu_s      = i_item.payload_byte[7];
        fu_e      = i_item.payload_byte[6];
        last      = i_item.last_of_packet;
        ab        = 1'b0;

        if (i_item.first_of_packet) begin
            // packet header; an open unit may be abandoned here
            ab = (r_kind == KIND_SINGLE) && truncated;
            if (r_in_frag && (truncated || nal_type != TYPE_FU_A)) begin
                ab        = 1'b1;
                n_in_frag = 1'b0;
            end
            n_frag_end = 1'b0;
            if (nal_type < TYPE_FIRST_OTHER) begin
                o_cmd_valid      = 1'b1;
                o_cmd.prefix     = 1'b1;
                o_cmd.data       = i_item.payload_byte;
                o_cmd.has_byte   = 1'b1;
                o_cmd.unit_end   = last;
                o_cmd.unit_abort = ab;
                n_kind           = KIND_SINGLE;
                n_pos            = last ? POS_HDR : POS_BODY;
            end else begin
                if (ab) begin
                    o_cmd_valid      = 1'b1;
                    o_cmd.unit_abort = 1'b1;
                end
                if (nal_type == TYPE_FU_A) begin
                    n_f_nri = i_item.payload_byte[7:5];
                    n_kind  = KIND_FU_A;
                    n_pos   = last ? POS_HDR : POS_FUHDR;
                end else begin
                    n_kind = KIND_DROP;
                    n_pos  = last ? POS_HDR : POS_BODY;
                end
            end
        end else if (r_pos == POS_HDR) begin
            // stray byte outside a packet
        end else if (r_kind == KIND_SINGLE) begin
            o_cmd_valid    = 1'b1;
            o_cmd.data     = i_item.payload_byte;
            o_cmd.has_byte = 1'b1;
            o_cmd.unit_end = last;
        end else if (r_kind == KIND_FU_A && r_pos == POS_FUHDR) begin
            // FU header: start, continuation or orphan
            if (fu_s) begin
                n_in_frag        = 1'b1;
                n_frag_end       = fu_e;
                o_cmd_valid      = 1'b1;
                o_cmd.prefix     = 1'b1;
                o_cmd.data       = {r_f_nri, i_item.payload_byte[4:0]};
                o_cmd.has_byte   = 1'b1;
                o_cmd.unit_end   = last && fu_e;
                o_cmd.unit_abort = r_in_frag;
                n_pos            = POS_BODY;
            end else if (r_in_frag) begin
                n_frag_end = fu_e;
                if (last && fu_e) begin
                    o_cmd_valid    = 1'b1;
                    o_cmd.unit_end = 1'b1;
                end
                n_pos = POS_BODY;
            end else begin
                n_kind = KIND_DROP;
                n_pos  = POS_BODY;
            end
            if (last && fu_e) begin
                n_in_frag = 1'b0;
            end
        end else if (r_kind == KIND_FU_A) begin
            o_cmd_valid    = 1'b1;
            o_cmd.data     = i_item.payload_byte;
            o_cmd.has_byte = 1'b1;
            o_cmd.unit_end = last && r_frag_end;
            if (last && r_frag_end) begin
                n_in_frag = 1'b0;
            end
        end

        // end of packet: back to waiting for a header
        if (last) begin
            n_pos      = POS_HDR;
            n_kind     = KIND_DROP;
            n_frag_end = 1'b0;
        end
    end

    // packet state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_HDR;
            r_kind     <= KIND_DROP;
            r_f_nri    <= '0;
            r_in_frag  <= 1'b0;
            r_frag_end <= 1'b0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_kind     <= n_kind;
            r_f_nri    <= n_f_nri;
            r_in_frag  <= n_in_frag;
            r_frag_end <= n_frag_end;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rtp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtp_queue
    import rtp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rtp_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtp_back
    import rtp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    logic [1:0] r_step;
    logic       r_valid;
    t_out_item  r_item;

    t_out_item  beat;
    logic       load;
    logic       is_final;

    assign load      = i_cmd_valid && (!r_valid || i_pop);
    assign is_final  = !i_cmd.prefix || (r_step == STEP_HEADER);
    assign o_cmd_pop = load && is_final;
    assign o_empty   = !r_valid;
    assign o_item    = r_item;

    // expand the head command into the beat for this step
    always_comb begin
        beat = '0;
        if (i_cmd.prefix && r_step != STEP_HEADER) begin
            beat.out_byte   = (r_step == STEP_ONE) ? START_LAST : START_ZERO;
            beat.has_byte   = 1'b1;
            beat.unit_abort = (r_step == STEP_FIRST) ? i_cmd.unit_abort : 1'b0;
        end else begin
            beat.out_byte     = i_cmd.data;
            beat.has_byte     = i_cmd.has_byte;
            beat.unit_end     = i_cmd.unit_end;
            beat.unit_abort   = i_cmd.prefix ? 1'b0 : i_cmd.unit_abort;
            beat.last_of_item = 1'b1;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= beat;
        end
    end

    // output valid and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= STEP_FIRST;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= is_final ? STEP_FIRST : r_step + 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rtp_h264_depacketizer.sv]
`timescale 1ns / 1ps
`default_nettype none

// RTP H.264 depacketizer (single NAL unit and FU-A packets) giving an Annex B
// byte stream. Payload bytes are pushed one per beat with packet first/last
// marks; results are popped one per beat. A byte that opens a unit yields four
// result beats (00 00 01 and the header), any other byte at most one, so the
// block sustains one input byte per cycle on body bytes while the queue is not
// full; the output stage emits one result beat a cycle while results are popped.
// A command queue of DEPTH entries between the classifier and the output stage
// absorbs the bursts of unit-opening bytes; full rises only once it fills. The
// first result beat of a byte passes through the queue slot and the output
// register before it shows on the result ports. Bytes that give no result
// (stray or dropped bytes) are accepted one per cycle unless the queue is full.
module rtp_h264_depacketizer
    import rtp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_item i_data,
    output logic          empty,
    input  wire logic     pop,
    output t_out_item     o_data
);

    logic accept;
    logic cmd_valid;
    t_cmd cmd;
    logic q_full;
    logic q_empty;
    t_cmd q_head;
    logic q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    rtp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_data),
        .i_accept    (accept),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    rtp_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && cmd_valid),
        .i_cmd   (cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    rtp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_head),
        .i_cmd_valid (!q_empty),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_data)
    );

endmodule

`default_nettype wire

[hw/rtl/rtp_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtp_chk
    import rtp_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      empty,
    input wire logic      pop,
    input wire t_out_item o_data
);

    // a waiting result beat holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_data)))
        else $error("result beat changed while stalled");

    // marker-only beats carry a zero byte
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_data.has_byte) |-> (o_data.out_byte == 8'h00))
        else $error("marker beat with nonzero byte");

    // a marker-only beat is always the last one of its input byte
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_data.has_byte) |-> o_data.last_of_item)
        else $error("marker beat not last of item");

    // a unit ends only on the last beat of an input byte
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_data.unit_end) |-> o_data.last_of_item)
        else $error("unit end before last beat of item");

    // nothing waits right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result present after reset");

endmodule

bind rtp_h264_depacketizer rtp_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_data  (o_data)
);

`default_nettype wire
